FILE: sv/blpg_pkg.sv
package blpg_pkg;

	// Field and register widths fixed by the interface
	localparam int COORD_BITS_DEF = 13;
	localparam int CFG_BITS       = 13;
	localparam int CFG_INDEX_BITS = 1;
	localparam int IDX_BITS       = 24;
	localparam int COLOUR_BITS    = 8;

	// Configuration register indexes and reset values
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [CFG_BITS-1:0]       WIDTH_RESET      = 13'd1800;
	localparam logic [CFG_BITS-1:0]       HEIGHT_RESET     = 13'd1400;

	// Command codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// Control from the input stage to the line tracker
	typedef struct packed {
		logic load;
		logic step;
	} trk_ctl_t;

endpackage

FILE: sv/blpg_setup.sv
module blpg_setup #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output logic                         steep,
	output logic signed [COORD_BITS-1:0] major_start,
	output logic signed [COORD_BITS-1:0] major_stop,
	output logic signed [COORD_BITS-1:0] minor_start,
	output logic        [COORD_BITS:0]   major_delta,
	output logic        [COORD_BITS:0]   minor_delta,
	output logic signed [COORD_BITS+1:0] error_init,
	output logic                         step_negative
);
	import blpg_pkg::*;

	logic signed [COORD_BITS:0]   dx;
	logic signed [COORD_BITS:0]   dy;
	logic        [COORD_BITS:0]   adx;
	logic        [COORD_BITS:0]   ady;
	logic signed [COORD_BITS-1:0] a0;
	logic signed [COORD_BITS-1:0] a1;
	logic signed [COORD_BITS-1:0] b0;
	logic signed [COORD_BITS-1:0] b1;
	logic                         flip;
	logic signed [COORD_BITS-1:0] b0_o;
	logic signed [COORD_BITS-1:0] b1_o;
	logic        [COORD_BITS:0]   half;

	// Deltas and their magnitudes
	assign dx  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
	assign dy  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
	assign adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
	assign ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
	assign steep = ady > adx;

	// Swap axes for a steep line
	assign a0 = steep ? y_start : x_start;
	assign a1 = steep ? y_end   : x_end;
	assign b0 = steep ? x_start : y_start;
	assign b1 = steep ? x_end   : y_end;

	// Order endpoints along the major axis
	assign flip        = a0 > a1;
	assign major_start = flip ? a1 : a0;
	assign major_stop  = flip ? a0 : a1;
	assign b0_o        = flip ? b1 : b0;
	assign b1_o        = flip ? b0 : b1;
	assign minor_start = b0_o;

	// Magnitudes do not depend on the endpoint order
	assign major_delta   = steep ? ady : adx;
	assign minor_delta   = steep ? adx : ady;
	assign half          = major_delta >> 1;
	assign error_init    = -$signed({1'b0, half});
	assign step_negative = !(b0_o < b1_o);

endmodule

FILE: sv/blpg_tracker.sv
module blpg_tracker #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  blpg_pkg::trk_ctl_t                  ctl,
	input  logic signed [COORD_BITS-1:0]        x_start,
	input  logic signed [COORD_BITS-1:0]        y_start,
	input  logic signed [COORD_BITS-1:0]        x_end,
	input  logic signed [COORD_BITS-1:0]        y_end,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    red_in,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    green_in,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    blue_in,
	output logic                                line_active,
	output logic signed [COORD_BITS-1:0]        pix_x,
	output logic signed [COORD_BITS-1:0]        pix_y,
	output logic                                pix_last,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    red_cur,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    green_cur,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    blue_cur
);
	import blpg_pkg::*;

	localparam int ERR_BITS = COORD_BITS + 2;

	logic                         su_steep;
	logic signed [COORD_BITS-1:0] su_maj;
	logic signed [COORD_BITS-1:0] su_end;
	logic signed [COORD_BITS-1:0] su_min;
	logic        [COORD_BITS:0]   su_mdel;
	logic        [COORD_BITS:0]   su_ndel;
	logic signed [ERR_BITS-1:0]   su_err;
	logic                         su_neg;

	logic                         active_q;
	logic                         steep_q;
	logic signed [COORD_BITS-1:0] maj_q;
	logic signed [COORD_BITS-1:0] end_q;
	logic signed [COORD_BITS-1:0] min_q;
	logic        [COORD_BITS:0]   mdel_q;
	logic        [COORD_BITS:0]   ndel_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         neg_q;
	logic [COLOUR_BITS-1:0]       red_q;
	logic [COLOUR_BITS-1:0]       green_q;
	logic [COLOUR_BITS-1:0]       blue_q;

	logic signed [ERR_BITS-1:0]   err_add;
	logic                         minor_move;

	blpg_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.steep        (su_steep),
		.major_start  (su_maj),
		.major_stop   (su_end),
		.minor_start  (su_min),
		.major_delta  (su_mdel),
		.minor_delta  (su_ndel),
		.error_init   (su_err),
		.step_negative(su_neg)
	);

	// Current pixel from the tracked position
	assign pix_x      = steep_q ? min_q : maj_q;
	assign pix_y      = steep_q ? maj_q : min_q;
	assign pix_last   = maj_q == end_q;
	assign err_add    = err_q + $signed({1'b0, ndel_q});
	assign minor_move = err_add > 0;

	// Track line activity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
		end else if (ctl.step && pix_last) begin
			active_q <= 1'b0;
		end
	end

	// Load a new line or advance one pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep_q <= 1'b0;
			maj_q   <= '0;
			end_q   <= '0;
			min_q   <= '0;
			mdel_q  <= '0;
			ndel_q  <= '0;
			err_q   <= '0;
			neg_q   <= 1'b0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (ctl.load) begin
			steep_q <= su_steep;
			maj_q   <= su_maj;
			end_q   <= su_end;
			min_q   <= su_min;
			mdel_q  <= su_mdel;
			ndel_q  <= su_ndel;
			err_q   <= su_err;
			neg_q   <= su_neg;
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
		end else if (ctl.step && !pix_last) begin
			maj_q <= maj_q + COORD_BITS'(1);
			if (minor_move) begin
				min_q <= neg_q ? min_q - COORD_BITS'(1) : min_q + COORD_BITS'(1);
				err_q <= err_add - $signed({1'b0, mdel_q});
			end else begin
				err_q <= err_add;
			end
		end
	end

	assign line_active = active_q;
	assign red_cur     = red_q;
	assign green_cur   = green_q;
	assign blue_cur    = blue_q;

endmodule

FILE: sv/blpg_emit.sv
module blpg_emit #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [blpg_pkg::CFG_BITS-1:0]       image_width,
	input  logic [blpg_pkg::CFG_BITS-1:0]       image_height,
	input  logic signed [COORD_BITS-1:0]        pix_x,
	input  logic signed [COORD_BITS-1:0]        pix_y,
	input  logic                                pix_last,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    red_cur,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    green_cur,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]    blue_cur,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_free,
	output logic signed [COORD_BITS-1:0]        pixel_x,
	output logic signed [COORD_BITS-1:0]        pixel_y,
	output logic [blpg_pkg::IDX_BITS-1:0]       pixel_index,
	output logic                                write_enable,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    red_out,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    green_out,
	output logic [blpg_pkg::COLOUR_BITS-1:0]    blue_out,
	output logic                                last_pixel
);
	import blpg_pkg::*;

	localparam int CMP_BITS  = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
	localparam int PROD_BITS = COORD_BITS + CFG_BITS;

	logic [COORD_BITS-1:0] px_u;
	logic [COORD_BITS-1:0] py_u;
	logic                  in_image;
	logic [PROD_BITS-1:0]  prod;
	logic [IDX_BITS-1:0]   idx;

	logic                         valid_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic [IDX_BITS-1:0]          idx_q;
	logic                         we_q;
	logic [COLOUR_BITS-1:0]       red_q;
	logic [COLOUR_BITS-1:0]       green_q;
	logic [COLOUR_BITS-1:0]       blue_q;
	logic                         last_q;

	// Clip against the image and form the linear index
	assign px_u     = pix_x;
	assign py_u     = pix_y;
	assign in_image = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1] &&
	                  (CMP_BITS'(px_u) < CMP_BITS'(image_width)) &&
	                  (CMP_BITS'(py_u) < CMP_BITS'(image_height));
	assign prod     = PROD_BITS'(py_u) * PROD_BITS'(image_width);
	assign idx      = in_image ? IDX_BITS'(prod) + IDX_BITS'(px_u) : '0;

	assign out_free = !valid_q || out_ready;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			px_q    <= pix_x;
			py_q    <= pix_y;
			idx_q   <= idx;
			we_q    <= in_image;
			red_q   <= red_cur;
			green_q <= green_cur;
			blue_q  <= blue_cur;
			last_q  <= pix_last;
		end
	end

	assign out_valid    = valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign pixel_index  = idx_q;
	assign write_enable = we_q;
	assign red_out      = red_q;
	assign green_out    = green_q;
	assign blue_out     = blue_q;
	assign last_pixel   = last_q;

endmodule

FILE: sv/bresenham_line_pixel_generator.sv
// Bresenham line pixel generator.
// Input channel (in_valid/in_ready): func = start carries two endpoints and a
// colour and sets up a new line, dropping any line still in progress; it gives
// no result. func = step asks for the next pixel of the active line and gives
// one result; a step with no active line is consumed and gives nothing.
// Output channel (out_valid/out_ready): pixel position, linear index
// y*image_width+x (zero when clipped), write_enable for pixels inside the
// image, the line colour, and last_pixel on the endpoint with the larger major-axis coordinate.
// Configuration: cfg_write/cfg_index/cfg_data write image_width or
// image_height; write them only while no transaction is in flight.
// A step transaction passes through the input register, then the result
// register. Throughput is one item per cycle while the receiver does not
// stall; the per-pixel error update and the y*width multiply each fit in
// the single stage between the two registers.
// Reset clears the line state and both valid flags; width and height return
// to 1800 and 1400. When the receiver stalls, the result register holds and
// the input register fills, so in_ready drops after one more pixel step.
module bresenham_line_pixel_generator #(
	parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [blpg_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [blpg_pkg::CFG_BITS-1:0]             cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic                                      func,
	input  logic signed [COORD_BITS-1:0]              x_start,
	input  logic signed [COORD_BITS-1:0]              y_start,
	input  logic signed [COORD_BITS-1:0]              x_end,
	input  logic signed [COORD_BITS-1:0]              y_end,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]          red_in,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]          green_in,
	input  logic [blpg_pkg::COLOUR_BITS-1:0]          blue_in,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [COORD_BITS-1:0]              pixel_x,
	output logic signed [COORD_BITS-1:0]              pixel_y,
	output logic [blpg_pkg::IDX_BITS-1:0]             pixel_index,
	output logic                                      write_enable,
	output logic [blpg_pkg::COLOUR_BITS-1:0]          red_out,
	output logic [blpg_pkg::COLOUR_BITS-1:0]          green_out,
	output logic [blpg_pkg::COLOUR_BITS-1:0]          blue_out,
	output logic                                      last_pixel
);
	import blpg_pkg::*;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;

	logic                         valid_s1;
	logic                         func_s1;
	logic signed [COORD_BITS-1:0] x0_s1;
	logic signed [COORD_BITS-1:0] y0_s1;
	logic signed [COORD_BITS-1:0] x1_s1;
	logic signed [COORD_BITS-1:0] y1_s1;
	logic [COLOUR_BITS-1:0]       red_s1;
	logic [COLOUR_BITS-1:0]       green_s1;
	logic [COLOUR_BITS-1:0]       blue_s1;

	trk_ctl_t                     trk_ctl;
	logic                         advance;
	logic                         line_active;
	logic                         out_free;
	logic signed [COORD_BITS-1:0] pix_x;
	logic signed [COORD_BITS-1:0] pix_y;
	logic                         pix_last;
	logic [COLOUR_BITS-1:0]       red_cur;
	logic [COLOUR_BITS-1:0]       green_cur;
	logic [COLOUR_BITS-1:0]       blue_cur;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Drain the input register unless a pixel must wait for the result register
	assign advance = valid_s1 && (func_s1 == FUNC_START || !line_active || out_free);
	assign in_ready = !valid_s1 || advance;
	assign trk_ctl.load = advance && func_s1 == FUNC_START;
	assign trk_ctl.step = advance && func_s1 == FUNC_STEP && line_active;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= func;
			x0_s1    <= x_start;
			y0_s1    <= y_start;
			x1_s1    <= x_end;
			y1_s1    <= y_end;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	blpg_tracker #(
		.COORD_BITS(COORD_BITS)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (trk_ctl),
		.x_start    (x0_s1),
		.y_start    (y0_s1),
		.x_end      (x1_s1),
		.y_end      (y1_s1),
		.red_in     (red_s1),
		.green_in   (green_s1),
		.blue_in    (blue_s1),
		.line_active(line_active),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.pix_last   (pix_last),
		.red_cur    (red_cur),
		.green_cur  (green_cur),
		.blue_cur   (blue_cur)
	);

	blpg_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (trk_ctl.step),
		.image_width (width_q),
		.image_height(height_q),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.pix_last    (pix_last),
		.red_cur     (red_cur),
		.green_cur   (green_cur),
		.blue_cur    (blue_cur),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_free    (out_free),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_index (pixel_index),
		.write_enable(write_enable),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_pixel  (last_pixel)
	);

	// A pixel step always lands in the result register
	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		trk_ctl.step |=> out_valid)
		else $error("pixel step did not produce a result");

	// The pixel at the far end of the major-axis walk closes the line
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		trk_ctl.step && pix_last |=> !line_active)
		else $error("line still active after its last pixel");

	// An enabled write never has a negative coordinate
	a_write_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
		else $error("write enabled for a pixel outside the image");

endmodule

FILE: tb/bresenham_line_pixel_generator_tb.sv
module bresenham_line_pixel_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import blpg_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int COORD_MIN = -(1 << (CW - 1));
	localparam int COORD_MAX = (1 << (CW - 1)) - 1;
	localparam int STALL_LIMIT = 1000;

	// One pixel as the block reports it
	typedef struct packed {
		logic [CW-1:0]          x;
		logic [CW-1:0]          y;
		logic [IDX_BITS-1:0]    index;
		logic                   we;
		logic [COLOUR_BITS-1:0] red;
		logic [COLOUR_BITS-1:0] green;
		logic [COLOUR_BITS-1:0] blue;
		logic                   last;
	} pixel_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]       cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic signed [CW-1:0]      x_start, y_start, x_end, y_end;
	logic [COLOUR_BITS-1:0]    red_in, green_in, blue_in;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [CW-1:0]      pixel_x, pixel_y;
	logic [IDX_BITS-1:0]       pixel_index;
	logic                      write_enable;
	logic [COLOUR_BITS-1:0]    red_out, green_out, blue_out;
	logic                      last_pixel;

	bresenham_line_pixel_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_index(pixel_index),
		.write_enable(write_enable), .red_out(red_out), .green_out(green_out),
		.blue_out(blue_out), .last_pixel(last_pixel)
	);

	always #10 clk = ~clk;

	// Image size as last written
	logic [CFG_BITS-1:0] img_width = WIDTH_RESET;
	logic [CFG_BITS-1:0] img_height = HEIGHT_RESET;

	// Line tracker state
	logic                   ln_active = 1'b0;
	logic                   ln_steep = 1'b0;
	logic signed [CW-1:0]   ln_major = '0;
	logic signed [CW-1:0]   ln_major_end = '0;
	logic signed [CW-1:0]   ln_minor = '0;
	logic [CW:0]            ln_major_delta = '0;
	logic [CW:0]            ln_minor_delta = '0;
	logic signed [CW+1:0]   ln_error = '0;
	logic                   ln_minor_neg = 1'b0;
	logic [COLOUR_BITS-1:0] ln_red = '0, ln_green = '0, ln_blue = '0;

	pixel_t      expected_pixels[$];
	int          mismatches = 0;
	int          items_done = 0;
	int          quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	function automatic int abs_int(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_coord(int v);
		return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// Coordinate anywhere, near the origin, or near an image border
	function automatic int pick_coord(int border);
		case ($urandom_range(3))
			0: return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
			1: return int'($urandom_range(40)) - 20;
			default: return clamp_coord(border + int'($urandom_range(40)) - 20);
		endcase
	endfunction

	// Advance the line tracker by one accepted transaction
	task automatic rasterize_item(input logic fn, input logic signed [CW-1:0] xs, ys, xe, ye,
			input logic [COLOUR_BITS-1:0] r, g, b);
		int x0, y0, x1, y1, t, e, idx;
		logic signed [CW-1:0] px, py;
		logic in_image;
		pixel_t pix;
		if (fn == FUNC_START) begin
			x0 = xs;
			y0 = ys;
			x1 = xe;
			y1 = ye;
			ln_steep = abs_int(y1 - y0) > abs_int(x1 - x0);
			if (ln_steep) begin
				t = x0; x0 = y0; y0 = t;
				t = x1; x1 = y1; y1 = t;
			end
			if (x0 > x1) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			ln_major = CW'(x0);
			ln_major_end = CW'(x1);
			ln_minor = CW'(y0);
			ln_major_delta = (CW+1)'(x1 - x0);
			ln_minor_delta = (CW+1)'(abs_int(y1 - y0));
			e = -((x1 - x0) >>> 1);
			ln_error = (CW+2)'(e);
			ln_minor_neg = !(y0 < y1);
			ln_red = r;
			ln_green = g;
			ln_blue = b;
			ln_active = 1'b1;
		end else if (ln_active) begin
			px = ln_steep ? ln_minor : ln_major;
			py = ln_steep ? ln_major : ln_minor;
			in_image = px >= 0 && int'(px) < int'(img_width) &&
				py >= 0 && int'(py) < int'(img_height);
			idx = in_image ? int'(py) * int'(img_width) + int'(px) : 0;
			pix.x = px;
			pix.y = py;
			pix.index = idx[IDX_BITS-1:0];
			pix.we = in_image;
			pix.red = ln_red;
			pix.green = ln_green;
			pix.blue = ln_blue;
			pix.last = (ln_major == ln_major_end);
			expected_pixels.push_back(pix);
			// Drop the line on its end point, else take one Bresenham step
			if (pix.last) begin
				ln_active = 1'b0;
			end else begin
				ln_major = ln_major + CW'(1);
				e = int'(ln_error) + int'(ln_minor_delta);
				if (e > 0) begin
					ln_minor = ln_minor_neg ? ln_minor - CW'(1) : ln_minor + CW'(1);
					e = e - int'(ln_major_delta);
				end
				ln_error = (CW+2)'(e);
			end
		end
	endtask

	// Offer one input transaction and hold it until accepted
	task automatic send_item(input logic fn, input logic signed [CW-1:0] xs, ys, xe, ye,
			input logic [COLOUR_BITS-1:0] r, g, b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		if (fn == FUNC_START || ln_active)
			items_done++;
		rasterize_item(fn, xs, ys, xe, ye, r, g, b);
	endtask

	// Start a line, then ask for a number of pixels with junk payload
	task automatic draw_line(input int xa, ya, xb, yb, input logic [23:0] rgb, input int steps);
		send_item(FUNC_START, CW'(xa), CW'(ya), CW'(xb), CW'(yb),
			rgb[23:16], rgb[15:8], rgb[7:0]);
		repeat (steps)
			send_item(FUNC_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
				CW'($urandom), COLOUR_BITS'($urandom), COLOUR_BITS'($urandom),
				COLOUR_BITS'($urandom));
	endtask

	// Hold off input until every pixel is back and the pipeline is empty
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both size registers while idle
	task automatic set_image_size(input int w, h);
		settle_block();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_BITS'(w);
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_BITS'(h);
		@(negedge clk);
		cfg_write <= 1'b0;
		img_width = CFG_BITS'(w);
		img_height = CFG_BITS'(h);
	endtask

	// Endpoint extremes, restarts, steep and single-point lines at reset size
	task automatic test_directed_lines();
		send_item(FUNC_STEP, '0, '0, '0, '0, '0, '0, '0);
		draw_line(0, 0, 0, 0, 24'hff00ff, 2);
		draw_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'h000000, 2);
		draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'hffffff, 2);
		draw_line(1799, 1399, 1801, 1395, 24'h123456, 5);
		draw_line(3, -2, -2, 3, 24'h807f01, 6);
		draw_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN + 2, 24'h5a5aa5, 3);
	endtask

	// Clipping and index at the size register extremes
	task automatic test_image_registers();
		set_image_size(0, 5);
		draw_line(0, 0, 3, 2, 24'h010203, 4);
		set_image_size(8191, 8191);
		draw_line(4000, 4095, 4003, 4095, 24'hfedcba, 4);
		draw_line(-1, 0, 1, 0, 24'h0f0f0f, 3);
		set_image_size(1, 1);
		draw_line(-1, -1, 1, 1, 24'hf0f0f0, 3);
		set_image_size(4096, 0);
		draw_line(5, 5, 5, 5, 24'h777777, 1);
		set_image_size(4096, 4096);
		draw_line(4093, 4090, 4095, 4095, 24'h3c3c3c, 6);
	endtask

	// Mostly complete lines, some overrun past the end, some cut short
	task automatic test_random_lines(input int count, input int w, h);
		int x0, y0, x1, y1, reach, span, steps, sel, goal;
		set_image_size(w, h);
		goal = items_done + count;
		while (items_done < goal) begin
			sel = $urandom_range(99);
			reach = (sel < 88) ? 24 : ((sel < 97) ? 200 : COORD_MAX - COORD_MIN);
			x0 = pick_coord(int'(img_width));
			y0 = pick_coord(int'(img_height));
			x1 = clamp_coord(x0 + int'($urandom_range(2 * reach)) - reach);
			y1 = clamp_coord(y0 + int'($urandom_range(2 * reach)) - reach);
			span = (abs_int(x1 - x0) > abs_int(y1 - y0)) ? abs_int(x1 - x0) : abs_int(y1 - y0);
			sel = $urandom_range(99);
			if (span >= 300)
				steps = $urandom_range(1, 40);
			else if (sel < 85)
				steps = span + 1;
			else if (sel < 95)
				steps = span + 1 + $urandom_range(1, 3);
			else
				steps = $urandom_range(span);
			draw_line(x0, y0, x1, y1, 24'($urandom), steps);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each output transaction with the oldest expected pixel
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t ns: unexpected pixel x=0x%0h y=0x%0h", $time,
					$unsigned(pixel_x), $unsigned(pixel_y));
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_x", want.x, $unsigned(pixel_x));
				check_field("pixel_y", want.y, $unsigned(pixel_y));
				check_field("pixel_index", want.index, pixel_index);
				check_field("write_enable", want.we, write_enable);
				check_field("red_out", want.red, red_out);
				check_field("green_out", want.green, green_out);
				check_field("blue_out", want.blue, blue_out);
				check_field("last_pixel", want.last, last_pixel);
			end
		end
	end

	// Receiver stalls at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_START;
		x_start = '0;
		y_start = '0;
		x_end = '0;
		y_end = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 21;
		recv_idle_pct = 64;
		test_directed_lines();
		test_image_registers();
		test_random_lines(500, 640, 480);

		send_idle_pct = 64;
		recv_idle_pct = 21;
		test_random_lines(500, 4096, 4096);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_lines(500, $urandom_range(1, 4096), $urandom_range(1, 4096));

		settle_block();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/blpg_pkg.sv
sv/blpg_setup.sv
sv/blpg_tracker.sv
sv/blpg_emit.sv
sv/bresenham_line_pixel_generator.sv
tb/bresenham_line_pixel_generator_tb.sv
